// ===== sv/hrsp_pkg.sv =====
// Shared types, character codes and result codes for the HTTP request stream parser.
package hrsp_pkg;

  // Result lanes produced by one input byte at most, and the width of a lane count.
  localparam int NUM_LANES = 5;
  localparam int LANE_W    = $clog2(NUM_LANES);
  localparam int CNT_W     = $clog2(NUM_LANES + 1);

  // Characters that steer the parse.
  localparam logic [7:0] CHR_SP    = 8'h20;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_COLON = 8'h3A;

  // Status codes carried by the final result of a message.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_LINE   = 2'd1;
  localparam logic [1:0] ST_BAD_METHOD = 2'd2;
  localparam logic [1:0] ST_BAD_HEADER = 2'd3;

  // Method codes reported with the request line end.
  localparam logic METHOD_GET  = 1'b0;
  localparam logic METHOD_POST = 1'b1;

  typedef enum logic [2:0] {
    KIND_FILE    = 3'd0,
    KIND_HOST    = 3'd1,
    KIND_KEY     = 3'd2,
    KIND_VALUE   = 3'd3,
    KIND_HDR_END = 3'd4,
    KIND_BODY    = 3'd5,
    KIND_REQ_END = 3'd6,
    KIND_STATUS  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    PH_METHOD = 3'd0,
    PH_FILE   = 3'd1,
    PH_HOST   = 3'd2,
    PH_KEY    = 3'd3,
    PH_VALUE  = 3'd4,
    PH_BODY   = 3'd5,
    PH_ERROR  = 3'd6
  } phase_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        method;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // The results caused by one input byte, in order.
  typedef struct packed {
    result_t [NUM_LANES-1:0] res;
    logic [CNT_W-1:0]        cnt;
  } grp_t;

  // Parser state carried from byte to byte.
  typedef struct packed {
    phase_t     phase;
    logic       held_cr;
    logic       held_colon;
    logic [2:0] mlen;
    logic       get_ok;
    logic       post_ok;
    logic       extra;
    logic       line_has;
    logic       value_has;
    logic [1:0] err;
  } pstate_t;

  localparam pstate_t RESET_STATE = '{
    phase:     PH_METHOD,
    held_cr:   1'b0,
    held_colon: 1'b0,
    mlen:      3'd0,
    get_ok:    1'b1,
    post_ok:   1'b1,
    extra:     1'b0,
    line_has:  1'b0,
    value_has: 1'b0,
    err:       ST_OK
  };

endpackage

// ===== sv/hrsp_parse.sv =====
// Parser state register and the single-pass step logic that turns one byte into results.
module hrsp_parse import hrsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  logic [7:0] byte_q,
  input  logic       eom_q,
  output grp_t       grp
);

  localparam int NUM_CAND = 9;

  // Outcome of one data byte: new state and up to two results.
  typedef struct packed {
    pstate_t s;
    result_t r0;
    result_t r1;
    logic    v0;
    logic    v1;
  } dstep_t;

  // Outcome of a line end: new state and up to one result.
  typedef struct packed {
    pstate_t s;
    result_t r;
    logic    v;
  } lstep_t;

  pstate_t st;
  pstate_t st_next;
  pstate_t s;
  dstep_t  d_cr;
  dstep_t  d_b;
  dstep_t  d_eom;
  lstep_t  l_lf;
  lstep_t  l_eom;
  logic    take_b;
  result_t cand [NUM_CAND];
  logic [NUM_CAND-1:0] cv;
  logic [CNT_W-1:0]    cnt;

  function automatic logic [7:0] get_char(input logic [1:0] i);
    case (i)
      2'd0:    return 8'h67;
      2'd1:    return 8'h65;
      2'd2:    return 8'h74;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] i);
    case (i)
      2'd0:    return 8'h70;
      2'd1:    return 8'h6F;
      2'd2:    return 8'h73;
      default: return 8'h74;
    endcase
  endfunction

  function automatic result_t mk(input kind_t k, input logic [7:0] d);
    result_t r;
    r = '0;
    r.kind = k;
    r.data = d;
    return r;
  endfunction

  function automatic pstate_t fail_st(input pstate_t s_in, input logic [1:0] code);
    pstate_t t;
    t = s_in;
    t.err = code;
    t.phase = PH_ERROR;
    t.held_cr = 1'b0;
    t.held_colon = 1'b0;
    return t;
  endfunction

  // One data byte after CR LF resolution.
  function automatic dstep_t data_fn(input pstate_t s_in, input logic [7:0] b);
    dstep_t     d;
    logic [7:0] c;
    d = '0;
    d.s = s_in;
    c = ((b >= 8'h41) && (b <= 8'h5A)) ? b + 8'h20 : b;
    case (s_in.phase)
      PH_METHOD: begin
        if (b == CHR_SP) begin
          d.s.phase = PH_FILE;
        end else begin
          if ((s_in.mlen >= 3'd3) || (c != get_char(s_in.mlen[1:0]))) d.s.get_ok = 1'b0;
          if ((s_in.mlen >= 3'd4) || (c != post_char(s_in.mlen[1:0]))) d.s.post_ok = 1'b0;
          if (s_in.mlen != 3'd7) d.s.mlen = s_in.mlen + 3'd1;
        end
      end
      PH_FILE: begin
        if (b == CHR_SP) begin
          d.s.phase = PH_HOST;
        end else begin
          d.r0 = mk(KIND_FILE, b);
          d.v0 = 1'b1;
        end
      end
      PH_HOST: begin
        if (b == CHR_SP) begin
          d.s.extra = 1'b1;
        end else if (!s_in.extra) begin
          d.r0 = mk(KIND_HOST, b);
          d.v0 = 1'b1;
        end
      end
      PH_KEY: begin
        if (s_in.held_colon) begin
          d.s.held_colon = 1'b0;
          if (b == CHR_SP) begin
            // Colon-space splits the line; an empty key is an error.
            if (!s_in.line_has) d.s = fail_st(d.s, ST_BAD_HEADER);
            else d.s.phase = PH_VALUE;
          end else begin
            d.r0 = mk(KIND_KEY, CHR_COLON);
            d.v0 = 1'b1;
            d.s.line_has = 1'b1;
            if (b == CHR_COLON) begin
              d.s.held_colon = 1'b1;
            end else begin
              d.r1 = mk(KIND_KEY, b);
              d.v1 = 1'b1;
            end
          end
        end else if (b == CHR_COLON) begin
          d.s.held_colon = 1'b1;
        end else begin
          d.r0 = mk(KIND_KEY, b);
          d.v0 = 1'b1;
          d.s.line_has = 1'b1;
        end
      end
      PH_VALUE: begin
        d.r0 = mk(KIND_VALUE, b);
        d.v0 = 1'b1;
        d.s.value_has = 1'b1;
      end
      PH_BODY: begin
        d.r0 = mk(KIND_BODY, b);
        d.v0 = 1'b1;
      end
      default: begin
      end
    endcase
    return d;
  endfunction

  // Judgment of the line that just ended.
  function automatic lstep_t line_fn(input pstate_t s_in);
    lstep_t l;
    l = '0;
    l.s = s_in;
    case (s_in.phase)
      PH_METHOD, PH_FILE: begin
        l.s = fail_st(s_in, ST_BAD_LINE);
      end
      PH_HOST: begin
        if (s_in.extra) begin
          l.s = fail_st(s_in, ST_BAD_LINE);
        end else if (s_in.get_ok && (s_in.mlen == 3'd3)) begin
          l.r = mk(KIND_REQ_END, 8'h00);
          l.r.method = METHOD_GET;
          l.v = 1'b1;
          l.s.phase = PH_KEY;
          l.s.line_has = 1'b0;
        end else if (s_in.post_ok && (s_in.mlen == 3'd4)) begin
          l.r = mk(KIND_REQ_END, 8'h00);
          l.r.method = METHOD_POST;
          l.v = 1'b1;
          l.s.phase = PH_KEY;
          l.s.line_has = 1'b0;
        end else begin
          l.s = fail_st(s_in, ST_BAD_METHOD);
        end
      end
      PH_KEY: begin
        if (s_in.held_colon || s_in.line_has) l.s = fail_st(s_in, ST_BAD_HEADER);
        else l.s.phase = PH_BODY;
        l.s.held_colon = 1'b0;
      end
      PH_VALUE: begin
        if (!s_in.value_has) begin
          l.s = fail_st(s_in, ST_BAD_HEADER);
        end else begin
          l.r = mk(KIND_HDR_END, 8'h00);
          l.v = 1'b1;
          l.s.phase = PH_KEY;
          l.s.line_has = 1'b0;
          l.s.value_has = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return l;
  endfunction

  // Step logic: resolve a held CR, take the byte, then close the message on its last byte.
  always_comb begin
    s = st;
    d_cr = '0;
    d_b = '0;
    d_eom = '0;
    l_lf = '0;
    l_eom = '0;
    take_b = 1'b0;
    for (int i = 0; i < NUM_CAND; i++) cand[i] = '0;
    cv = '0;

    if (s.phase != PH_ERROR) begin
      if (s.held_cr) begin
        s.held_cr = 1'b0;
        if (byte_q == CHR_LF) begin
          l_lf = line_fn(s);
          s = l_lf.s;
          cand[2] = l_lf.r;
          cv[2] = l_lf.v;
        end else begin
          d_cr = data_fn(s, CHR_CR);
          s = d_cr.s;
          cand[0] = d_cr.r0;
          cv[0] = d_cr.v0;
          cand[1] = d_cr.r1;
          cv[1] = d_cr.v1;
          take_b = (s.phase != PH_ERROR);
        end
      end else begin
        take_b = 1'b1;
      end
      if (take_b) begin
        if (byte_q == CHR_CR) begin
          s.held_cr = 1'b1;
        end else begin
          d_b = data_fn(s, byte_q);
          s = d_b.s;
          cand[3] = d_b.r0;
          cv[3] = d_b.v0;
          cand[4] = d_b.r1;
          cv[4] = d_b.v1;
        end
      end
    end

    if (eom_q) begin
      // A held CR is data at the end of the message.
      if ((s.phase != PH_ERROR) && s.held_cr) begin
        s.held_cr = 1'b0;
        d_eom = data_fn(s, CHR_CR);
        s = d_eom.s;
        cand[5] = d_eom.r0;
        cv[5] = d_eom.v0;
        cand[6] = d_eom.r1;
        cv[6] = d_eom.v1;
      end
      if (s.phase != PH_ERROR) begin
        l_eom = line_fn(s);
        s = l_eom.s;
        cand[7] = l_eom.r;
        cv[7] = l_eom.v;
      end
      cand[8] = mk(KIND_STATUS, 8'h00);
      cand[8].status = s.err;
      cand[8].last = 1'b1;
      cv[8] = 1'b1;
      s = RESET_STATE;
    end
    st_next = s;
  end

  // Pack the valid candidates into consecutive lanes.
  always_comb begin
    grp.res = '0;
    cnt = '0;
    for (int i = 0; i < NUM_CAND; i++) begin
      if (cv[i] && (cnt < CNT_W'(NUM_LANES))) begin
        grp.res[cnt[LANE_W-1:0]] = cand[i];
        cnt = cnt + CNT_W'(1);
      end
    end
    grp.cnt = cnt;
  end

  // Parser state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= RESET_STATE;
    end else if (step_en) begin
      st <= st_next;
    end
  end

endmodule

// ===== sv/hrsp_queue.sv =====
// Result lane register that hands out the results of one byte, one per cycle while out_ready is high.
module hrsp_queue import hrsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  grp_t    grp_in,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t res_out,
  output logic    free
);

  result_t [NUM_LANES-1:0] lanes;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        idx;
  logic                    at_last;

  // A result is pending while the read index is below the lane count.
  assign out_valid = (idx < count);
  assign res_out   = out_valid ? lanes[idx[LANE_W-1:0]] : '0;
  assign at_last   = out_valid && ((idx + CNT_W'(1)) == count);
  assign free      = !out_valid || (out_ready && at_last);

  // Control: lane count and read index.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx <= '0;
    end else if (load) begin
      count <= grp_in.cnt;
      idx <= '0;
    end else if (out_valid && out_ready) begin
      idx <= idx + CNT_W'(1);
    end
  end

  // Result payload lanes.
  always_ff @(posedge clk) begin
    if (load) begin
      lanes <= grp_in.res;
    end
  end

endmodule

// ===== sv/http_request_stream_parser_core.sv =====
// Top level of the HTTP request stream parser: input register, step logic and result lanes.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   byte_in, end_of_message
//  out      output     out_valid / out_ready kind, data_byte, method_code, status_code,
//                                            last_result
//
// A request is registered on acceptance and stepped through the parser once the result lanes
// are free. The output port delivers one result per cycle while out_ready is high, so a request
// that yields n results holds the input register until its last result is taken; one request
// per cycle is taken while each yields at most one result and the output does not stall. The
// last byte of a message yields up to five. Reset clears the parser state and all valid flags.
// A stall at the output holds the current result and the input register.
module http_request_stream_parser_core import hrsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] data_byte,
  output logic       method_code,
  output logic [1:0] status_code,
  output logic       last_result
);

  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_eom;
  logic       q_free;
  logic       advance;
  grp_t       grp;
  result_t    res;

  // The held request moves on when the lanes can take its results.
  assign advance  = item_valid && q_free;
  assign in_ready = !item_valid || q_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_byte <= byte_in;
      item_eom <= end_of_message;
    end
  end

  hrsp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .byte_q  (item_byte),
    .eom_q   (item_eom),
    .grp     (grp)
  );

  hrsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .grp_in    (grp),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res),
    .free      (q_free)
  );

  // Result fields.
  assign kind        = res.kind;
  assign data_byte   = res.data;
  assign method_code = res.method;
  assign status_code = res.status;
  assign last_result = res.last;

`ifndef NO_ASSERTIONS
  // Only the status result closes a message.
  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_result == (kind == KIND_STATUS)))
    else $error("last_result does not match status kind");

  // A method code appears only with the request line end.
  a_method_only_req_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != KIND_REQ_END)) |-> !method_code)
    else $error("method_code set on a non request line end result");

  // A request that cannot move on stays in the input register unchanged.
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !q_free) |=> (item_valid && $stable(item_byte) && $stable(item_eom)))
    else $error("held request lost or changed");
`endif

endmodule

// ===== test/http_request_stream_parser_core_test.sv =====
// Self-checking testbench for the HTTP request stream parser core.
`timescale 1ns / 1ps

module http_request_stream_parser_core_test import hrsp_pkg::*;;

  localparam int RANDOM_ITEMS = 290;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PERCENT = 36;

  localparam logic [23:0] GET_WORD  = "get";
  localparam logic [31:0] POST_WORD = "post";

  // One directed request; a row with has_status carries its status result typed in.
  typedef struct packed {
    logic [7:0] value;
    logic       eom;
    logic       has_status;
    logic [1:0] status;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] byte_in = 8'h00;
  logic       end_of_message = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       method_code;
  logic [1:0] status_code;
  logic       last_result;

  // Directed message: mixed-case POST, colon inside a key, a header, a body
  // ending in a held CR, then two one-byte messages at the byte extremes.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h70, 1'b0, 1'b0, ST_OK}, '{8'h4F, 1'b0, 1'b0, ST_OK},
    '{8'h73, 1'b0, 1'b0, ST_OK}, '{8'h54, 1'b0, 1'b0, ST_OK},
    '{8'h20, 1'b0, 1'b0, ST_OK}, '{8'h2F, 1'b0, 1'b0, ST_OK},
    '{8'h20, 1'b0, 1'b0, ST_OK}, '{8'h68, 1'b0, 1'b0, ST_OK},
    '{8'h0D, 1'b0, 1'b0, ST_OK}, '{8'h0A, 1'b0, 1'b0, ST_OK},
    '{8'h6B, 1'b0, 1'b0, ST_OK}, '{8'h3A, 1'b0, 1'b0, ST_OK},
    '{8'h61, 1'b0, 1'b0, ST_OK}, '{8'h3A, 1'b0, 1'b0, ST_OK},
    '{8'h20, 1'b0, 1'b0, ST_OK}, '{8'h76, 1'b0, 1'b0, ST_OK},
    '{8'h0D, 1'b0, 1'b0, ST_OK}, '{8'h0A, 1'b0, 1'b0, ST_OK},
    '{8'h0D, 1'b0, 1'b0, ST_OK}, '{8'h0A, 1'b0, 1'b0, ST_OK},
    '{8'h62, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'h0D, 1'b1, 1'b0, ST_OK},
    '{8'h00, 1'b1, 1'b1, ST_BAD_LINE},
    '{8'hFF, 1'b1, 1'b1, ST_BAD_LINE}
  };

  // Parser state as the testbench tracks it.
  phase_t     parse_phase;
  logic       cr_pending;
  logic       colon_pending;
  logic [2:0] method_len;
  logic       could_be_get;
  logic       could_be_post;
  logic       host_overflow;
  logic       key_started;
  logic       value_started;
  logic [1:0] fault;
  int         step_results;

  result_t    parse_results_due [$];
  result_t    oldest_due;
  logic [7:0] message_bytes [$];
  int         failures = 0;
  int         cycle_count = 0;
  int         random_sent = 0;
  logic       steady_stream = 1'b0;

  http_request_stream_parser_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .byte_in        (byte_in),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .method_code    (method_code),
    .status_code    (status_code),
    .last_result    (last_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Parser state restore, used at start and after every message.
  function automatic void clear_parser();
    parse_phase   = PH_METHOD;
    cr_pending    = 1'b0;
    colon_pending = 1'b0;
    method_len    = 3'd0;
    could_be_get  = 1'b1;
    could_be_post = 1'b1;
    host_overflow = 1'b0;
    key_started   = 1'b0;
    value_started = 1'b0;
    fault         = ST_OK;
  endfunction

  // Queue one expected result; a single byte yields no more than the lane count.
  function automatic void emit_due(kind_t k, logic [7:0] d, logic m, logic [1:0] s, logic l);
    result_t r;
    r.kind   = k;
    r.data   = d;
    r.method = m;
    r.status = s;
    r.last   = l;
    if (step_results < NUM_LANES) begin
      parse_results_due.insert(parse_results_due.size(), r);
      step_results++;
    end
  endfunction

  function automatic void enter_error(logic [1:0] code);
    fault         = code;
    parse_phase   = PH_ERROR;
    cr_pending    = 1'b0;
    colon_pending = 1'b0;
  endfunction

  function automatic void take_key_byte(logic [7:0] b);
    emit_due(KIND_KEY, b, 1'b0, ST_OK, 1'b0);
    key_started = 1'b1;
  endfunction

  // One data byte, with CR LF already resolved.
  function automatic void take_data_byte(logic [7:0] b);
    logic [7:0] c;
    case (parse_phase)
      PH_METHOD: begin
        if (b == CHR_SP) begin
          parse_phase = PH_FILE;
        end else begin
          // Fold upper case letters and track whether the token still spells a method.
          c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
          if (method_len >= 3) could_be_get = 1'b0;
          else if (c != GET_WORD[23 - 8 * method_len -: 8]) could_be_get = 1'b0;
          if (method_len >= 4) could_be_post = 1'b0;
          else if (c != POST_WORD[31 - 8 * method_len -: 8]) could_be_post = 1'b0;
          if (method_len < 7) method_len++;
        end
      end
      PH_FILE: begin
        if (b == CHR_SP) parse_phase = PH_HOST;
        else emit_due(KIND_FILE, b, 1'b0, ST_OK, 1'b0);
      end
      PH_HOST: begin
        if (b == CHR_SP) host_overflow = 1'b1;
        else if (!host_overflow) emit_due(KIND_HOST, b, 1'b0, ST_OK, 1'b0);
      end
      PH_KEY: begin
        // A held colon followed by a space ends the key.
        if (colon_pending) begin
          colon_pending = 1'b0;
          if (b == CHR_SP) begin
            if (!key_started) enter_error(ST_BAD_HEADER);
            else parse_phase = PH_VALUE;
            return;
          end
          take_key_byte(CHR_COLON);
        end
        if (b == CHR_COLON) colon_pending = 1'b1;
        else take_key_byte(b);
      end
      PH_VALUE: begin
        emit_due(KIND_VALUE, b, 1'b0, ST_OK, 1'b0);
        value_started = 1'b1;
      end
      PH_BODY: begin
        emit_due(KIND_BODY, b, 1'b0, ST_OK, 1'b0);
      end
      default: begin
      end
    endcase
  endfunction

  // Judge the line that has just ended.
  function automatic void close_line();
    case (parse_phase)
      PH_METHOD, PH_FILE: begin
        enter_error(ST_BAD_LINE);
      end
      PH_HOST: begin
        if (host_overflow) begin
          enter_error(ST_BAD_LINE);
        end else if (could_be_get && method_len == 3) begin
          emit_due(KIND_REQ_END, 8'h00, METHOD_GET, ST_OK, 1'b0);
          parse_phase = PH_KEY;
          key_started = 1'b0;
        end else if (could_be_post && method_len == 4) begin
          emit_due(KIND_REQ_END, 8'h00, METHOD_POST, ST_OK, 1'b0);
          parse_phase = PH_KEY;
          key_started = 1'b0;
        end else begin
          enter_error(ST_BAD_METHOD);
        end
      end
      PH_KEY: begin
        if (colon_pending || key_started) enter_error(ST_BAD_HEADER);
        else parse_phase = PH_BODY;
        colon_pending = 1'b0;
      end
      PH_VALUE: begin
        if (!value_started) begin
          enter_error(ST_BAD_HEADER);
        end else begin
          emit_due(KIND_HDR_END, 8'h00, 1'b0, ST_OK, 1'b0);
          parse_phase   = PH_KEY;
          key_started   = 1'b0;
          value_started = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Raw byte: a CR is held until the next byte shows whether it ends a line.
  function automatic void take_raw_byte(logic [7:0] b);
    if (cr_pending) begin
      cr_pending = 1'b0;
      if (b == CHR_LF) begin
        close_line();
        return;
      end
      take_data_byte(CHR_CR);
      if (parse_phase == PH_ERROR) return;
    end
    if (b == CHR_CR) cr_pending = 1'b1;
    else take_data_byte(b);
  endfunction

  // Expected results of one accepted request.
  function automatic void split_byte(logic [7:0] b, logic eom);
    step_results = 0;
    if (parse_phase != PH_ERROR) take_raw_byte(b);
    if (eom) begin
      if (parse_phase != PH_ERROR && cr_pending) begin
        cr_pending = 1'b0;
        take_data_byte(CHR_CR);
      end
      if (parse_phase != PH_ERROR) close_line();
      emit_due(KIND_STATUS, 8'h00, 1'b0, fault, 1'b1);
      clear_parser();
    end
  endfunction

  // Any byte, with the steering characters made frequent.
  function automatic logic [7:0] noise_char();
    case ($urandom_range(7))
      0: return CHR_SP;
      1: return CHR_CR;
      2: return CHR_LF;
      3: return CHR_COLON;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Any byte that does not steer the parse.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CHR_SP || c == CHR_CR || c == CHR_LF || c == CHR_COLON);
    return c;
  endfunction

  // Append one byte to the message under construction.
  function automatic void add_byte(logic [7:0] b);
    message_bytes.insert(message_bytes.size(), b);
  endfunction

  // Build one random message: mostly well formed with random content, some
  // carrying one flaw, some cut short, and a few plain noise.
  function automatic void build_message();
    logic [7:0] c;
    logic       is_post;
    int         word_len;
    int         token_len;
    int         flaw;
    int         keep;
    message_bytes.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) add_byte(noise_char());
      return;
    end

    // Method token in mixed case, now and then too short or too long.
    is_post  = ($urandom_range(1) != 0);
    word_len = is_post ? 4 : 3;
    case ($urandom_range(9))
      0: token_len = word_len - 1;
      1: token_len = word_len + 1;
      2: token_len = 9;
      default: token_len = word_len;
    endcase
    for (int i = 0; i < token_len; i++) begin
      if (i < word_len) c = is_post ? POST_WORD[31 - 8 * i -: 8] : GET_WORD[23 - 8 * i -: 8];
      else c = 8'($urandom_range(8'h61, 8'h7A));
      if ($urandom_range(1)) c = c & 8'hDF;
      add_byte(c);
    end

    // File and host tokens, sometimes with one space too few or too many.
    add_byte(CHR_SP);
    repeat ($urandom_range(0, 3)) add_byte(plain_char());
    if ($urandom_range(19) != 0) add_byte(CHR_SP);
    repeat ($urandom_range(0, 3)) add_byte(plain_char());
    if ($urandom_range(11) == 0) begin
      add_byte(CHR_SP);
      add_byte(plain_char());
    end
    add_byte(CHR_CR);
    add_byte(CHR_LF);

    // Header lines; a few lack the key, the split or the value, or hold colons in the key.
    repeat ($urandom_range(0, 2)) begin
      flaw = $urandom_range(19);
      if (flaw != 0) repeat ($urandom_range(1, 3)) add_byte(plain_char());
      if (flaw == 1) begin
        add_byte(CHR_COLON);
        add_byte(plain_char());
      end
      if (flaw == 4) add_byte(CHR_COLON);
      if (flaw != 2) begin
        add_byte(CHR_COLON);
        add_byte(CHR_SP);
      end
      if (flaw != 3) begin
        repeat ($urandom_range(1, 3)) begin
          add_byte($urandom_range(4) == 0 ? noise_char() : plain_char());
        end
      end
      add_byte(CHR_CR);
      add_byte(CHR_LF);
    end

    // Empty line and body.
    if ($urandom_range(9) < 7) begin
      add_byte(CHR_CR);
      add_byte(CHR_LF);
      repeat ($urandom_range(0, 5)) add_byte(noise_char());
    end

    // Cut some messages short.
    if ($urandom_range(9) == 0 && message_bytes.size() > 1) begin
      keep = $urandom_range(1, message_bytes.size() - 1);
      while (message_bytes.size() > keep) void'(message_bytes.pop_back());
    end
  endfunction

  // Present one request and return at the edge that accepts it.
  task automatic send_request(input logic [7:0] b, input logic eom);
    if (!steady_stream && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PERCENT) @(posedge clk);
    end
    in_valid       <= 1'b1;
    byte_in        <= b;
    end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the sender off until every expected result has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk);
    while (parse_results_due.size() != 0);
  endtask

  // Receiver stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady_stream || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Compare each accepted result with the oldest one expected.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (parse_results_due.size() == 0) begin
        if (failures < 10) begin
          $display("unexpected result: kind=%0d data=%02h method=%0d status=%0d last=%0d",
                   kind, data_byte, method_code, status_code, last_result);
        end
        failures++;
      end else begin
        oldest_due = parse_results_due.pop_front();
        if (kind !== oldest_due.kind || data_byte !== oldest_due.data ||
            method_code !== oldest_due.method || status_code !== oldest_due.status ||
            last_result !== oldest_due.last) begin
          if (failures < 10) begin
            $write("mismatch at cycle %0d: expected kind=%0d data=%02h method=%0d ",
                   cycle_count, oldest_due.kind, oldest_due.data, oldest_due.method);
            $write("status=%0d last=%0d, ", oldest_due.status, oldest_due.last);
            $display("got kind=%0d data=%02h method=%0d status=%0d last=%0d",
                     kind, data_byte, method_code, status_code, last_result);
          end
          failures++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("http_request_stream_parser_core regression: fail");
      $finish;
    end
  end

  // Stimulus: reset, the directed table, a pause, then random messages.
  initial begin
    int      due_before;
    result_t typed_status;
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_request(directed_rows[r].value, directed_rows[r].eom);
      due_before = parse_results_due.size();
      split_byte(directed_rows[r].value, directed_rows[r].eom);
      if (directed_rows[r].has_status) begin
        while (parse_results_due.size() > due_before) void'(parse_results_due.pop_back());
        typed_status.kind   = KIND_STATUS;
        typed_status.data   = 8'h00;
        typed_status.method = 1'b0;
        typed_status.status = directed_rows[r].status;
        typed_status.last   = 1'b1;
        parse_results_due.insert(parse_results_due.size(), typed_status);
      end
    end
    wait_for_results();

    while (random_sent < RANDOM_ITEMS) begin
      steady_stream = (random_sent >= 120 && random_sent < 200);
      build_message();
      for (int i = 0; i < message_bytes.size(); i++) begin
        send_request(message_bytes[i], i == message_bytes.size() - 1);
        split_byte(message_bytes[i], i == message_bytes.size() - 1);
        random_sent++;
      end
    end
    steady_stream = 1'b0;

    // Drain and let any late result show up.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && parse_results_due.size() == 0) begin
      $display("http_request_stream_parser_core regression: pass");
    end else begin
      $display("http_request_stream_parser_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/hrsp_pkg.sv
sv/hrsp_parse.sv
sv/hrsp_queue.sv
sv/http_request_stream_parser_core.sv
test/http_request_stream_parser_core_test.sv
